FILE: rtl/core/rbfi_pkg.sv
`default_nettype none
package rbfi_pkg;

  localparam int MAX_HITS = 6;
  localparam int HALF     = 32768;
  localparam int DIV_W    = 48;
  localparam int DIV_CW   = 6;
  localparam int SQRT_N   = 32;
  localparam int SQRT_CW  = 5;
  localparam int CFG_IW   = 3;

  localparam logic [CFG_IW-1:0] REG_OBJ_ROW0  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_OBJ_ROW1  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_OBJ_ROW2  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INV_ROW0  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_INV_ROW1  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_INV_ROW2  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SURFACE_ID = 3'd6;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [31:0]        distance;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [7:0]         material;
    logic               last;
  } out_word_t;

  // signed q8.8 coefficient of column c
  function automatic logic signed [15:0] coef(input logic [63:0] row, input logic [1:0] c);
    logic signed [15:0] r;
    unique case (c)
      2'd0: r = signed'(row[15:0]);
      2'd1: r = signed'(row[31:16]);
      2'd2: r = signed'(row[47:32]);
      default: r = signed'(row[63:48]);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rbfi_div.sv
`default_nettype none
module rbfi_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [49:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);

  logic                          busy_r, done_r;
  logic [rbfi_pkg::DIV_CW-1:0]   cnt_r;
  logic                          neg_r;
  logic [rbfi_pkg::DIV_W-1:0]    nmag_r, quo_r;
  logic [31:0]                   rem_r, dmag_r;
  logic [32:0]                   rem_sh;
  logic                          ge;
  logic [49:0]                   num_abs;
  logic signed [49:0]            qs;

  assign num_abs = num[49] ? 50'(-num) : 50'(num);
  assign rem_sh  = {rem_r, nmag_r[rbfi_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rbfi_pkg::DIV_CW'(rbfi_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= num[49] ^ den[31];
      nmag_r <= num_abs[rbfi_pkg::DIV_W-1:0];
      dmag_r <= den[31] ? 32'(-den) : 32'(den);
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
      nmag_r <= {nmag_r[rbfi_pkg::DIV_W-2:0], 1'b0};
      quo_r  <= {quo_r[rbfi_pkg::DIV_W-2:0], ge};
    end
  end

  // truncating quotient, saturated to 32 bits
  always_comb begin
    qs = neg_r ? -signed'({2'b00, quo_r}) : signed'({2'b00, quo_r});
    if (qs > 50'sd2147483647)       quo = 32'sh7FFFFFFF;
    else if (qs < -50'sd2147483648) quo = 32'sh80000000;
    else                            quo = qs[31:0];
  end

  assign done = done_r;

endmodule
`default_nettype wire

FILE: rtl/core/rbfi_sqrt.sv
`default_nettype none
module rbfi_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] rad,
  output logic             done,
  output logic [31:0]      root
);

  logic                         busy_r, done_r;
  logic [rbfi_pkg::SQRT_CW-1:0] cnt_r;
  logic [63:0]                  rad_r;
  logic [31:0]                  root_r;
  logic [34:0]                  rem_r, rem_sh, trial;
  logic                         ge;

  assign rem_sh = {rem_r[32:0], rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rbfi_pkg::SQRT_CW'(rbfi_pkg::SQRT_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[30:0], ge};
      rad_r  <= {rad_r[61:0], 2'b00};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

FILE: rtl/core/ray_box_face_intersect_sorted_top.sv
`default_nettype none
// Ray against a transformed unit box. A ray word (Q16.16 origin and direction) is mapped
// into box space, tested against the six faces in the order +x -x +y -y +z -z, and every
// hit leaves as one result word in world space, sorted by distance (equal distances keep
// face order); a ray that hits nothing gives one word with hit clear. The last word of a
// ray has last set. One ray is worked at a time and in_stall stays high until the sorted
// list has been handed to the output register. All arithmetic goes through one 34x34
// multiplier with accumulator, a 48-step restoring divider and a 32-step square root.
// The transform comes first. Each face whose axis direction is nonzero then runs a
// division and clipping, a face with zero direction is skipped, and each hit adds the
// world point, squared distance and root; after the face scan the result words leave
// one per cycle while the output is free. The divider and square root take most time.
// Configuration must only be written while no ray is in flight.
module ray_box_face_intersect_sorted_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire rbfi_pkg::in_word_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rbfi_pkg::out_word_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rbfi_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [63:0]                   cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_XF   = 4'd1;  // world to box transform
  localparam logic [3:0] ST_FACE = 4'd2;  // pick next face, launch division
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_PB   = 4'd4;  // other two coordinates and clip
  localparam logic [3:0] ST_PT   = 4'd5;  // hit point back to world
  localparam logic [3:0] ST_SQ   = 4'd6;  // squared distance
  localparam logic [3:0] ST_ROOT = 4'd7;  // square root, then sorted insert
  localparam logic [3:0] ST_OUT  = 4'd8;

  // configuration
  logic [63:0] obj_r [3];
  logic [63:0] inv_r [3];
  logic [7:0]  sid_r;

  logic [3:0]  state_r, state_nxt;

  // ray and box-space values
  logic signed [31:0] wo_r [3];
  logic signed [31:0] wd_r [3];
  logic signed [31:0] oo_r [3];
  logic signed [31:0] od_r [3];
  logic signed [31:0] t_r;
  logic signed [17:0] p_r  [3];
  logic signed [31:0] pt_r [3];
  logic signed [51:0] acc_r;
  logic [63:0]        sq_r;

  // sequencing
  logic [1:0] row_r, col_r;
  logic       sel_d_r;
  logic [2:0] face_r;
  logic       ok_r;
  logic [2:0] n_r, k_r;

  // sorted hit list
  logic [31:0]        hl_dist_r [rbfi_pkg::MAX_HITS];
  logic signed [31:0] hl_pt_r   [rbfi_pkg::MAX_HITS][3];
  logic [2:0]         hl_face_r [rbfi_pkg::MAX_HITS];

  logic                out_valid_r;
  rbfi_pkg::out_word_t out_data_r, out_word;

  // shared multiplier and its operand selection
  logic signed [33:0] ma, mb, diff, mag;
  logic signed [67:0] prod;
  logic signed [51:0] base, acc_in, mac_sum, sh8;
  logic signed [31:0] sat_v;
  logic signed [52:0] pbv;
  logic               inside_b, ok_nxt;
  logic [64:0]        sq_sum;
  logic [63:0]        sq_nxt;
  logic [1:0]         axis;
  logic signed [17:0] h18;
  logic signed [33:0] hd;
  logic signed [49:0] div_num;
  logic               div_start, div_done, sq_start, sq_done;
  logic signed [31:0] div_q;
  logic [31:0]        root;
  logic               gt [rbfi_pkg::MAX_HITS];
  logic               out_load, in_acc;

  assign axis = face_r[2:1];
  assign h18  = face_r[0] ? -18'sd32768 : 18'sd32768;
  assign diff = 34'(wo_r[row_r]) - 34'(pt_r[row_r]);
  assign mag  = diff[33] ? -diff : diff;

  always_comb begin
    ma   = '0;
    mb   = '0;
    base = '0;
    unique case (state_r)
      ST_XF: begin
        ma   = 34'(rbfi_pkg::coef(inv_r[row_r], col_r));
        mb   = sel_d_r ? 34'(wd_r[col_r]) : 34'(wo_r[col_r]);
        base = sel_d_r ? '0 : (52'(rbfi_pkg::coef(inv_r[row_r], 2'd3)) <<< 16);
      end
      ST_PB: begin
        ma = 34'(t_r);
        mb = 34'(od_r[col_r]);
      end
      ST_PT: begin
        ma   = 34'(rbfi_pkg::coef(obj_r[row_r], col_r));
        mb   = 34'(p_r[col_r]);
        base = 52'(rbfi_pkg::coef(obj_r[row_r], 2'd3)) <<< 16;
      end
      ST_SQ: begin
        ma = mag;
        mb = mag;
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign acc_in  = (col_r == 2'd0) ? base : acc_r;
  assign mac_sum = acc_in + prod[51:0];
  assign sh8     = mac_sum >>> 8;
  assign sat_v   = (sh8 > 52'sd2147483647)  ? 32'sh7FFFFFFF :
                   (sh8 < -52'sd2147483648) ? 32'sh80000000 : sh8[31:0];

  // other coordinate at the face plane, exact
  assign pbv      = 53'(oo_r[col_r]) + 53'(signed'(prod[67:16]));
  assign inside_b = (pbv >= -53'sd32768) && (pbv <= 53'sd32768);
  assign ok_nxt   = ok_r & ((col_r == axis) | inside_b);

  // saturating sum of squares
  assign sq_sum = {1'b0, sq_r} + {1'b0, prod[63:0]};
  assign sq_nxt = sq_sum[64] ? '1 : sq_sum[63:0];

  assign hd      = 34'(h18) - 34'(oo_r[axis]);
  assign div_num = 50'(hd) <<< 16;

  assign div_start = (state_r == ST_FACE) && (face_r != 3'd6) && (od_r[axis] != '0);
  assign sq_start  = (state_r == ST_SQ) && (row_r == 2'd2);

  rbfi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (od_r[axis]),
    .done  (div_done),
    .quo   (div_q)
  );

  rbfi_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_nxt),
    .done  (sq_done),
    .root  (root)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_XF;
      ST_XF: begin
        if (row_r == 2'd2 && sel_d_r && col_r == 2'd2) state_nxt = ST_FACE;
      end
      ST_FACE: begin
        if (face_r == 3'd6) state_nxt = ST_OUT;
        else if (div_start) state_nxt = ST_DIV;
      end
      ST_DIV: if (div_done) state_nxt = ST_PB;
      ST_PB: begin
        if (col_r == 2'd2) state_nxt = ok_nxt ? ST_PT : ST_FACE;
      end
      ST_PT: if (row_r == 2'd2 && col_r == 2'd2) state_nxt = ST_SQ;
      ST_SQ: if (row_r == 2'd2) state_nxt = ST_ROOT;
      ST_ROOT: if (sq_done) state_nxt = ST_FACE;
      ST_OUT: begin
        if (out_load && (n_r == '0 || k_r == n_r - 1'b1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      face_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      sel_d_r     <= 1'b0;
      ok_r        <= 1'b0;
      sid_r       <= '0;
      for (int i = 0; i < 3; i++) begin
        obj_r[i] <= '0;
        inv_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rbfi_pkg::REG_OBJ_ROW0:   obj_r[0] <= cfg_data;
          rbfi_pkg::REG_OBJ_ROW1:   obj_r[1] <= cfg_data;
          rbfi_pkg::REG_OBJ_ROW2:   obj_r[2] <= cfg_data;
          rbfi_pkg::REG_INV_ROW0:   inv_r[0] <= cfg_data;
          rbfi_pkg::REG_INV_ROW1:   inv_r[1] <= cfg_data;
          rbfi_pkg::REG_INV_ROW2:   inv_r[2] <= cfg_data;
          rbfi_pkg::REG_SURFACE_ID: sid_r    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            row_r   <= '0;
            col_r   <= '0;
            sel_d_r <= 1'b0;
            face_r  <= '0;
            n_r     <= '0;
            k_r     <= '0;
          end
        end
        ST_XF: begin
          if (col_r == 2'd2) begin
            col_r   <= '0;
            sel_d_r <= ~sel_d_r;
            if (sel_d_r) row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_FACE: begin
          if (face_r != 3'd6 && !div_start) face_r <= face_r + 1'b1;
        end
        ST_DIV: begin
          col_r <= '0;
          ok_r  <= 1'b1;
        end
        ST_PB: begin
          ok_r <= ok_nxt;
          if (col_r == 2'd2) begin
            col_r <= '0;
            row_r <= '0;
            if (!ok_nxt) face_r <= face_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_PT: begin
          if (col_r == 2'd2) begin
            col_r <= '0;
            row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_SQ: begin
          row_r <= row_r + 1'b1;
        end
        ST_ROOT: begin
          if (sq_done) begin
            n_r    <= n_r + 1'b1;
            face_r <= face_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) k_r <= k_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      wo_r[0] <= in_data.origin_x;
      wo_r[1] <= in_data.origin_y;
      wo_r[2] <= in_data.origin_z;
      wd_r[0] <= in_data.dir_x;
      wd_r[1] <= in_data.dir_y;
      wd_r[2] <= in_data.dir_z;
    end
    if (state_r == ST_XF || state_r == ST_PT) acc_r <= mac_sum;
    if (state_r == ST_XF && col_r == 2'd2) begin
      if (sel_d_r) od_r[row_r] <= sat_v;
      else         oo_r[row_r] <= sat_v;
    end
    if (div_start) p_r[axis] <= h18;
    if (state_r == ST_DIV && div_done) t_r <= div_q;
    if (state_r == ST_PB && col_r != axis) p_r[col_r] <= pbv[17:0];
    if (state_r == ST_PT && col_r == 2'd2) pt_r[row_r] <= sh8[31:0];
    if (state_r == ST_PT) sq_r <= '0;
    if (state_r == ST_SQ) sq_r <= sq_nxt;
    if (out_load) out_data_r <= out_word;
  end

  // stable insert: the new hit goes after every stored hit of equal or smaller distance
  always_comb begin
    for (int j = 0; j < rbfi_pkg::MAX_HITS; j++) begin
      gt[j] = (3'(j) < n_r) && (hl_dist_r[j] > root);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ROOT && sq_done) begin
      if (gt[0] || n_r == '0) begin
        hl_dist_r[0] <= root;
        hl_face_r[0] <= face_r;
        for (int i = 0; i < 3; i++) hl_pt_r[0][i] <= pt_r[i];
      end
      for (int j = 1; j < rbfi_pkg::MAX_HITS; j++) begin
        if (gt[j-1]) begin
          hl_dist_r[j] <= hl_dist_r[j-1];
          hl_face_r[j] <= hl_face_r[j-1];
          for (int i = 0; i < 3; i++) hl_pt_r[j][i] <= hl_pt_r[j-1][i];
        end else if (gt[j] || 3'(j) == n_r) begin
          hl_dist_r[j] <= root;
          hl_face_r[j] <= face_r;
          for (int i = 0; i < 3; i++) hl_pt_r[j][i] <= pt_r[i];
        end
      end
    end
  end

  // result word from list entry k
  always_comb begin
    logic [2:0]         f;
    logic signed [31:0] nv [3];
    f = hl_face_r[k_r];
    for (int i = 0; i < 3; i++) begin
      nv[i] = 32'(rbfi_pkg::coef(obj_r[i], f[2:1])) <<< 8;
      if (f[0]) nv[i] = -nv[i];
    end
    out_word          = '0;
    out_word.last     = 1'b1;
    if (n_r != '0) begin
      out_word.hit      = 1'b1;
      out_word.distance = hl_dist_r[k_r];
      out_word.point_x  = hl_pt_r[k_r][0];
      out_word.point_y  = hl_pt_r[k_r][1];
      out_word.point_z  = hl_pt_r[k_r][2];
      out_word.normal_x = nv[0];
      out_word.normal_y = nv[1];
      out_word.normal_z = nv[2];
      out_word.material = sid_r;
      out_word.last     = (k_r == n_r - 1'b1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a miss word always closes its ray
  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.hit |-> out_data_r.last)
    else $error("miss word without last");

  // the hit list never overflows
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 3'(rbfi_pkg::MAX_HITS))
    else $error("hit list overflow");

  // divider and root only finish while the sequencer waits for them
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished out of turn");

  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == ST_ROOT)
    else $error("square root finished out of turn");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  // an index past the last register
  localparam logic [rbfi_pkg::CFG_IW-1:0] REG_NONE = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rbfi_pkg::in_word_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rbfi_pkg::out_word_t out_data;
  logic        cfg_we = 1'b0;
  logic [rbfi_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  ray_box_face_intersect_sorted_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the transform registers
  logic [63:0] obj_m [3];
  logic [63:0] inv_m [3];
  logic [7:0]  mat_id;

  rbfi_pkg::in_word_t  rays_pending [$];
  rbfi_pkg::out_word_t hits_expected [$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  // signed q8.8 coefficient of column c, widened
  function automatic longint cf(input logic [63:0] row, input int c);
    return longint'($signed(row[16*c +: 16]));
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // append one ray to the pending queue
  task automatic queue_ray(input rbfi_pkg::in_word_t w);
    rays_pending.insert(rays_pending.size(), w);
  endtask

  // works out every face hit of one ray, sorted by distance
  task automatic trace_ray(input rbfi_pkg::in_word_t w);
    longint wo [3], wd [3], oo [3], od [3], p [3], pt [3], nv [3];
    longint so, sd, h, t, s, m;
    longint unsigned q, sq;
    rbfi_pkg::out_word_t hl [rbfi_pkg::MAX_HITS];
    rbfi_pkg::out_word_t cur;
    int n, a, j;
    bit in_box;
    n = 0;
    wo[0] = w.origin_x; wo[1] = w.origin_y; wo[2] = w.origin_z;
    wd[0] = w.dir_x;    wd[1] = w.dir_y;    wd[2] = w.dir_z;
    // world to box space
    for (int i = 0; i < 3; i++) begin
      so = cf(inv_m[i], 3) * 65536;
      sd = 0;
      for (int c = 0; c < 3; c++) begin
        so += cf(inv_m[i], c) * wo[c];
        sd += cf(inv_m[i], c) * wd[c];
      end
      oo[i] = sat32(so >>> 8);
      od[i] = sat32(sd >>> 8);
    end
    // faces +x -x +y -y +z -z
    for (int f = 0; f < rbfi_pkg::MAX_HITS; f++) begin
      a = f >> 1;
      h = f[0] ? -rbfi_pkg::HALF : rbfi_pkg::HALF;
      if (od[a] == 0) continue;
      t = sat32(((h - oo[a]) * 65536) / od[a]);
      in_box = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (i == a) p[i] = h;
        else begin
          p[i] = oo[i] + ((t * od[i]) >>> 16);
          if (p[i] > rbfi_pkg::HALF || p[i] < -rbfi_pkg::HALF) in_box = 1'b0;
        end
      end
      if (!in_box) continue;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        s = cf(obj_m[i], 3) * 65536;
        for (int c = 0; c < 3; c++) s += cf(obj_m[i], c) * p[c];
        pt[i] = s >>> 8;
        nv[i] = f[0] ? -(cf(obj_m[i], a) * 256) : cf(obj_m[i], a) * 256;
        m = (wo[i] >= pt[i]) ? wo[i] - pt[i] : pt[i] - wo[i];
        // square wraps at 64 bits before the saturating sum
        q = longint'(m) * longint'(m);
        sq = (sq > 64'hFFFF_FFFF_FFFF_FFFF - q) ? 64'hFFFF_FFFF_FFFF_FFFF : sq + q;
      end
      hl[n] = '0;
      hl[n].hit = 1'b1;
      hl[n].distance = 32'(isqrt(sq));
      hl[n].point_x = pt[0][31:0]; hl[n].point_y = pt[1][31:0]; hl[n].point_z = pt[2][31:0];
      hl[n].normal_x = nv[0][31:0]; hl[n].normal_y = nv[1][31:0]; hl[n].normal_z = nv[2][31:0];
      hl[n].material = mat_id;
      n++;
    end
    // stable insertion sort, equal distances keep face order
    for (int k = 1; k < n; k++) begin
      cur = hl[k];
      j = k - 1;
      while (j >= 0 && hl[j].distance > cur.distance) begin
        hl[j + 1] = hl[j];
        j--;
      end
      hl[j + 1] = cur;
    end
    if (n == 0) begin
      cur = '0;
      cur.last = 1'b1;
      hits_expected.insert(hits_expected.size(), cur);
    end else begin
      for (int k = 0; k < n; k++) begin
        hl[k].last = (k == n - 1);
        hits_expected.insert(hits_expected.size(), hl[k]);
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // sender: fed from the pending queue, word held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) trace_ray(in_data);
      if (!in_valid || !in_stall) begin
        if (rays_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data <= rays_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    rbfi_pkg::out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (hits_expected.size() == 0) begin
        report("unexpected word", 64'(out_data.distance), 64'd0);
      end else begin
        e = hits_expected.pop_front();
        if (out_data.hit != e.hit) report("hit", out_data.hit, e.hit);
        if (out_data.distance != e.distance) report("distance", out_data.distance, e.distance);
        if (out_data.point_x != e.point_x) report("point_x", out_data.point_x, e.point_x);
        if (out_data.point_y != e.point_y) report("point_y", out_data.point_y, e.point_y);
        if (out_data.point_z != e.point_z) report("point_z", out_data.point_z, e.point_z);
        if (out_data.normal_x != e.normal_x) report("normal_x", out_data.normal_x, e.normal_x);
        if (out_data.normal_y != e.normal_y) report("normal_y", out_data.normal_y, e.normal_y);
        if (out_data.normal_z != e.normal_z) report("normal_z", out_data.normal_z, e.normal_z);
        if (out_data.material != e.material) report("material", out_data.material, e.material);
        if (out_data.last != e.last) report("last", out_data.last, e.last);
      end
    end
  end

  // watchdog: cycles of pending work with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (in_valid || rays_pending.size() > 0 || hits_expected.size() > 0)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // register write, mirrored into the shadow copy
  task automatic cfg_write(input logic [rbfi_pkg::CFG_IW-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= rbfi_pkg::REG_OBJ_ROW2) obj_m[idx] = val;
    else if (idx <= rbfi_pkg::REG_INV_ROW2) inv_m[idx - rbfi_pkg::REG_INV_ROW0] = val;
    else if (idx == rbfi_pkg::REG_SURFACE_ID) mat_id = val[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_transform(input logic [63:0] o0, o1, o2, i0, i1, i2, input logic [63:0] sid);
    cfg_write(rbfi_pkg::REG_OBJ_ROW0, o0);
    cfg_write(rbfi_pkg::REG_OBJ_ROW1, o1);
    cfg_write(rbfi_pkg::REG_OBJ_ROW2, o2);
    cfg_write(rbfi_pkg::REG_INV_ROW0, i0);
    cfg_write(rbfi_pkg::REG_INV_ROW1, i1);
    cfg_write(rbfi_pkg::REG_INV_ROW2, i2);
    cfg_write(rbfi_pkg::REG_SURFACE_ID, sid);
  endtask

  // sender pauses until every expected word is back, then a short settle
  task automatic drain;
    while (rays_pending.size() > 0 || in_valid || hits_expected.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic rbfi_pkg::in_word_t ray(input longint ox, oy, oz, dx, dy, dz);
    rbfi_pkg::in_word_t w;
    w.origin_x = ox[31:0]; w.origin_y = oy[31:0]; w.origin_z = oz[31:0];
    w.dir_x = dx[31:0];    w.dir_y = dy[31:0];    w.dir_z = dz[31:0];
    return w;
  endfunction

  // box space point to world space through the object rows
  function automatic longint to_world(input int r, input longint x, y, z);
    return (cf(obj_m[r], 3) * 65536 + cf(obj_m[r], 0) * x + cf(obj_m[r], 1) * y
            + cf(obj_m[r], 2) * z) >>> 8;
  endfunction

  // mostly rays aimed at a point in the box, the rest pure noise
  task automatic random_rays(input int count);
    longint sp [3], tp [3], ow [3], tw [3];
    int sh;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 80) begin
        for (int i = 0; i < 3; i++) begin
          sp[i] = $signed($urandom_range(32'h60000)) - 64'sh30000;
          tp[i] = $signed($urandom_range(32'h10000)) - 64'sh8000;
        end
        // sometimes start at the centre or aim at a point on a face
        if ($urandom_range(9) == 0) sp = '{0, 0, 0};
        if ($urandom_range(9) == 0) tp[$urandom_range(2)] = rbfi_pkg::HALF;
        for (int i = 0; i < 3; i++) begin
          ow[i] = to_world(i, sp[0], sp[1], sp[2]);
          tw[i] = to_world(i, tp[0], tp[1], tp[2]) - ow[i];
        end
        sh = $urandom_range(3);
        if ($urandom_range(1)) queue_ray(ray(ow[0], ow[1], ow[2],
                                tw[0] >>> sh, tw[1] >>> sh, tw[2] >>> sh));
        else queue_ray(ray(ow[0], ow[1], ow[2],
                                tw[0] <<< sh, tw[1] <<< sh, tw[2] <<< sh));
      end else begin
        queue_ray(ray($signed($urandom), $signed($urandom), $signed($urandom),
                      $signed($urandom), $signed($urandom), $signed($urandom)));
      end
    end
  endtask

  function automatic logic [63:0] rand_row;
    logic [63:0] r;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(3))
        0: r[16*c +: 16] = 16'h7FFF;
        1: r[16*c +: 16] = 16'h8000;
        default: r[16*c +: 16] = $urandom;
      endcase
    end
    return r;
  endfunction

  localparam longint MX = 64'sh7FFFFFFF;
  localparam longint MN = -64'sh80000000;

  initial begin
    for (int i = 0; i < 3; i++) begin
      obj_m[i] = '0;
      inv_m[i] = '0;
    end
    mat_id = '0;
    send_idle = 22;
    recv_idle = 47;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: every ray misses
    random_rays(8);
    drain();

    // identity both ways, surface id with junk above bit 7
    load_transform(64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
                   64'h0000_0100_0000_0000, 64'h0000_0000_0000_0100,
                   64'h0000_0000_0100_0000, 64'h0000_0100_0000_0000,
                   64'hDEAD_BEEF_0000_12A5);
    cfg_write(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);  // beyond the last register, ignored
    queue_ray(ray(0, 0, 0, 0, 0, 0));                  // zero direction
    queue_ray(ray(0, 0, 0, 32'h10000, 0, 0));          // centre, equal distances
    queue_ray(ray(0, 0, 0, -32'h10000, 0, 0));
    queue_ray(ray(0, 0, 0, 0, 32'h10000, 0));
    queue_ray(ray(0, 0, 0, 0, 0, -32'h10000));
    queue_ray(ray(-32'h20000, 0, 0, 32'h10000, 0, 0)); // only x planes
    queue_ray(ray(0, -32'h20000, 32'h8000, 0, 32'h10000, 0)); // grazing a face edge
    queue_ray(ray(-32'h20000, -32'h20000, 0, 32'h10000, 32'h10000, 0)); // corner
    queue_ray(ray(-32'h20000, -32'h20000, -32'h20000,
                  32'h10000, 32'h10000, 32'h10000));   // main diagonal
    queue_ray(ray(32'h20000, 32'h20000, 0, 32'h10000, 0, 0)); // miss
    queue_ray(ray(32'h20000, 0, 0, 32'h10000, 0, 0));  // hits behind origin
    queue_ray(ray(MX, MX, MX, MX, MX, MX));
    queue_ray(ray(MN, MN, MN, MN, MN, MN));
    queue_ray(ray(MX, MN, MX, MN, MX, MN));
    queue_ray(ray(0, 0, 0, 1, 1, 1));                  // tiny direction
    queue_ray(ray(0, 0, 0, MX, 1, -1));
    queue_ray(ray(MN, 0, 0, MX, 0, 0));                // far origin, big distance
    queue_ray(ray(-1, -1, -1, -1, -1, -1));
    random_rays(110);
    drain();

    // scale by two with translation, receiver now idles less than sender
    send_idle = 47;
    recv_idle = 22;
    load_transform(64'h0180_0000_0000_0200, 64'hFF00_0000_0200_0000,
                   64'h0040_0200_0000_0000, 64'hFF40_0000_0000_0080,
                   64'h0080_0000_0080_0000, 64'hFFE0_0080_0000_0000, 64'h00);
    random_rays(110);
    drain();

    // quarter turn about z, no idling from here on
    send_idle = 0;
    recv_idle = 0;
    load_transform(64'h0000_0000_FF00_0000, 64'h0000_0000_0000_0100,
                   64'h0000_0100_0000_0000, 64'h0000_0000_0100_0000,
                   64'h0000_0000_0000_FF00, 64'h0000_0100_0000_0000, 64'hFF);
    random_rays(110);
    drain();

    // extreme coefficients
    load_transform(rand_row(), rand_row(), rand_row(), rand_row(), rand_row(), rand_row(),
                   $urandom);
    random_rays(60);
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
